// File: rtl/core/rpc_pkg.sv
// shared types, angle constants and elaboration helpers for the rect/polar converter
`timescale 1ns / 1ps

package rpc_pkg;

    // request kinds
    typedef enum logic {
        REQ_RECT  = 1'b0,
        REQ_POLAR = 1'b1
    } t_req_mode;

    // angle datapath is q30 radians, 34 bits signed covers about +/- 8 rad
    localparam int Z_WIDTH     = 34;
    localparam int GUARD_BITS  = 16;
    localparam int MAX_ITER    = 24;

    localparam logic signed [Z_WIDTH-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // atan(2^-i) in q30
    localparam logic signed [Z_WIDTH-1:0] ATAN_Q30 [MAX_ITER] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_w;
        rem   = n;
        res   = '0;
        bit_w = 64'h4000_0000_0000_0000;
        while (bit_w > rem) begin
            bit_w = bit_w >> 2;
        end
        while (bit_w != '0) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // cordic gain k in q30, from the product of (1 + 2^-2i)
    function automatic logic [63:0] gain_root(input int iter);
        logic [63:0] prod;
        prod = 64'd1 << 30;
        for (int i = 0; i < iter && i < MAX_ITER; i++) begin
            prod = prod + (prod >> (2 * i));
        end
        return isqrt64(prod << 30);
    endfunction

endpackage

// File: rtl/core/rect_polar_converter_top.sv
// pipelined cordic converter between rectangular and polar vector forms
`timescale 1ns / 1ps

// rect_polar_converter_top: one vector word in, one word out with x, y, magnitude and angle.
// req_type 0 takes (x, y) and runs cordic vectoring for magnitude and atan2; req_type 1
// takes (angle, magnitude) and runs cordic rotation for x = m*cos(a) and y = m*sin(a).
// coordinates and magnitude are signed with DATA_WIDTH-4 fraction bits, angles are radians
// with DATA_WIDTH-3 fraction bits, every result saturates to its range. the datapath is a
// straight pipeline: one input stage, one stage per micro-rotation, then abs, gain multiply,
// partial-product sum, rounding and a clamp/output register; a new word is taken every cycle
// unless the pipe is frozen. all stages share one advance enable: the pipe only freezes while
// the output register holds a word and the consumer stalls, so o_in_stall is asserted exactly
// then. the vector on the x axis (including the zero vector) bypasses the cordic result:
// magnitude |x|, angle 0 or pi.
module rect_polar_converter_top
    import rpc_pkg::*;
#(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_in_first,
    input  logic signed [DATA_WIDTH-1:0] i_in_second,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_out_x,
    output logic signed [DATA_WIDTH-1:0] o_out_y,
    output logic signed [DATA_WIDTH:0]   o_out_magnitude,
    output logic signed [DATA_WIDTH-1:0] o_out_angle
);

    // ------------------------------------------------------------------
    // widths
    // ------------------------------------------------------------------
    // coordinate datapath: input plus guard bits plus cordic growth
    localparam int XW    = DATA_WIDTH + GUARD_BITS + 2;
    // magnitude bits of a coordinate
    localparam int AW    = XW - 1;
    // padded so the split into a 32-bit low part and a high part always exists
    localparam int AW_P  = (AW > 32) ? AW : 33;
    localparam int HW    = AW_P - 32;
    // sum of the partial products
    localparam int RW    = AW_P + 1;
    localparam int RW1   = RW + 1;
    // rounded coordinate
    localparam int QW    = RW1 - GUARD_BITS;
    localparam int WP1   = DATA_WIDTH + 1;
    // input angle lsb sits this many bits above the q30 lsb
    localparam int SHIFT = 33 - DATA_WIDTH;

    // ------------------------------------------------------------------
    // constants worked out at elaboration
    // ------------------------------------------------------------------
    localparam logic [63:0] K_ROOT    = gain_root(ITERATIONS);
    localparam logic [63:0] GAIN_FULL = ((64'd1 << 62) + K_ROOT / 2) / K_ROOT;
    localparam logic [31:0] GAIN_Q32  = GAIN_FULL[31:0];

    localparam logic [63:0] MAG_FULL  = isqrt64(64'd1 << (2 * DATA_WIDTH - 1)) + 64'd1;
    localparam logic signed [WP1-1:0] MAG_MAX = MAG_FULL[WP1-1:0];

    localparam logic signed [Z_WIDTH-1:0] Z_HALF_LSB = Z_WIDTH'(1) << (SHIFT - 1);
    localparam logic signed [Z_WIDTH-1:0] PI_ROUND   = (PI_Q30 + Z_HALF_LSB) >>> SHIFT;
    localparam logic signed [WP1-1:0]     PI_OUT     = PI_ROUND[WP1-1:0];

    localparam logic signed [QW-1:0] LIM_Q   = QW'(1) << (DATA_WIDTH - 1);
    localparam logic signed [QW-1:0] COORD_HI = LIM_Q - QW'(1);
    localparam logic signed [QW-1:0] COORD_LO = -LIM_Q;
    localparam logic signed [QW-1:0] MAG_HI_Q = QW'(MAG_MAX);

    localparam logic [RW1-1:0] RND_POS = RW1'(1) << (GUARD_BITS - 1);
    localparam logic [RW1-1:0] RND_NEG = RND_POS + RW1'(1);

    // what travels beside the coordinates
    typedef struct packed {
        t_req_mode                    mode;
        logic                         axis;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
    } t_side;

    // ------------------------------------------------------------------
    // pipeline enable: freeze only when a finished word waits at a stalled output
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_adv;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    // ------------------------------------------------------------------
    // input stage: scale, quadrant fix for vectoring, angle fold for rotation
    // ------------------------------------------------------------------
    logic signed [XW-1:0]      w_ax;
    logic signed [XW-1:0]      w_bx;
    logic signed [Z_WIDTH-1:0] w_zin;
    logic signed [Z_WIDTH-1:0] w_zsub;
    logic signed [Z_WIDTH-1:0] w_zadd;
    logic signed [XW-1:0]      w_x0;
    logic signed [XW-1:0]      w_y0;
    logic signed [Z_WIDTH-1:0] w_z0;
    t_side                     w_side0;

    always_comb begin
        w_ax   = XW'(i_in_first) <<< GUARD_BITS;
        w_bx   = XW'(i_in_second) <<< GUARD_BITS;
        w_zin  = Z_WIDTH'(i_in_first) <<< SHIFT;
        w_zsub = w_zin - PI_Q30;
        w_zadd = w_zin + PI_Q30;

        w_side0.mode = t_req_mode'(i_req_type);
        w_side0.axis = (i_in_second == '0);
        w_side0.a    = i_in_first;
        w_side0.b    = i_in_second;

        unique case (w_side0.mode)
            REQ_RECT: begin
                // left half plane: turn by a quarter first
                if (i_in_first[DATA_WIDTH-1]) begin
                    if (!i_in_second[DATA_WIDTH-1]) begin
                        w_x0 = w_bx;
                        w_y0 = -w_ax;
                        w_z0 = HALF_PI_Q30;
                    end else begin
                        w_x0 = -w_bx;
                        w_y0 = w_ax;
                        w_z0 = -HALF_PI_Q30;
                    end
                end else begin
                    w_x0 = w_ax;
                    w_y0 = w_bx;
                    w_z0 = '0;
                end
            end
            REQ_POLAR: begin
                // wrap into +/- pi and fold into +/- pi/2 collapse into one step
                w_y0 = '0;
                if (w_zin > HALF_PI_Q30) begin
                    w_z0 = w_zsub;
                    w_x0 = -w_bx;
                end else if (w_zin < -HALF_PI_Q30) begin
                    w_z0 = w_zadd;
                    w_x0 = -w_bx;
                end else begin
                    w_z0 = w_zin;
                    w_x0 = w_bx;
                end
            end
            default: begin
                w_x0 = w_ax;
                w_y0 = w_bx;
                w_z0 = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // cordic stages, one micro-rotation each
    // ------------------------------------------------------------------
    logic signed [XW-1:0]      r_x    [ITERATIONS+1];
    logic signed [XW-1:0]      r_y    [ITERATIONS+1];
    logic signed [Z_WIDTH-1:0] r_z    [ITERATIONS+1];
    t_side                     r_side [ITERATIONS+1];
    logic [ITERATIONS:0]       r_valid;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x[0]    <= w_x0;
            r_y[0]    <= w_y0;
            r_z[0]    <= w_z0;
            r_side[0] <= w_side0;
        end
    end

    for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_iter
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        logic                 w_ccw;

        assign w_dx  = r_y[gi] >>> gi;
        assign w_dy  = r_x[gi] >>> gi;
        // rotation follows the sign of z, vectoring drives y toward zero
        assign w_ccw = (r_side[gi].mode == REQ_POLAR) ? !r_z[gi][Z_WIDTH-1]
                                                      : (r_y[gi][XW-1] || (r_y[gi] == '0));

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_ccw) begin
                    r_x[gi+1] <= r_x[gi] - w_dx;
                    r_y[gi+1] <= r_y[gi] + w_dy;
                    r_z[gi+1] <= r_z[gi] - ATAN_Q30[gi];
                end else begin
                    r_x[gi+1] <= r_x[gi] + w_dx;
                    r_y[gi+1] <= r_y[gi] - w_dy;
                    r_z[gi+1] <= r_z[gi] + ATAN_Q30[gi];
                end
                r_side[gi+1] <= r_side[gi];
            end
        end
    end

    // ------------------------------------------------------------------
    // abs stage: sign and magnitude ahead of the gain multiply
    // ------------------------------------------------------------------
    logic                      r_a_valid;
    logic                      r_a_sx;
    logic                      r_a_sy;
    logic [AW-1:0]             r_a_x;
    logic [AW-1:0]             r_a_y;
    logic signed [Z_WIDTH-1:0] r_a_z;
    t_side                     r_a_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_sx   <= r_x[ITERATIONS][XW-1];
            r_a_sy   <= r_y[ITERATIONS][XW-1];
            r_a_x    <= r_x[ITERATIONS][XW-1] ? AW'(-r_x[ITERATIONS]) : AW'(r_x[ITERATIONS]);
            r_a_y    <= r_y[ITERATIONS][XW-1] ? AW'(-r_y[ITERATIONS]) : AW'(r_y[ITERATIONS]);
            r_a_z    <= r_z[ITERATIONS];
            r_a_side <= r_side[ITERATIONS];
        end
    end

    // ------------------------------------------------------------------
    // multiply stage: |v| * (1/k) split into 32-bit low and high partial products
    // ------------------------------------------------------------------
    logic [AW_P-1:0] w_ext_x;
    logic [AW_P-1:0] w_ext_y;

    assign w_ext_x = AW_P'(r_a_x);
    assign w_ext_y = AW_P'(r_a_y);

    logic                      r_m_valid;
    logic                      r_m_sx;
    logic                      r_m_sy;
    logic [63:0]               r_m_xlo;
    logic [63:0]               r_m_ylo;
    logic [HW+31:0]            r_m_xhi;
    logic [HW+31:0]            r_m_yhi;
    logic signed [Z_WIDTH-1:0] r_m_z;
    t_side                     r_m_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_sx   <= r_a_sx;
            r_m_sy   <= r_a_sy;
            r_m_xlo  <= w_ext_x[31:0] * GAIN_Q32;
            r_m_ylo  <= w_ext_y[31:0] * GAIN_Q32;
            r_m_xhi  <= w_ext_x[AW_P-1:32] * GAIN_Q32;
            r_m_yhi  <= w_ext_y[AW_P-1:32] * GAIN_Q32;
            r_m_z    <= r_a_z;
            r_m_side <= r_a_side;
        end
    end

    // ------------------------------------------------------------------
    // sum stage: floor(|v| * gain / 2^32)
    // ------------------------------------------------------------------
    logic                      r_s_valid;
    logic                      r_s_sx;
    logic                      r_s_sy;
    logic [RW-1:0]             r_s_x;
    logic [RW-1:0]             r_s_y;
    logic signed [Z_WIDTH-1:0] r_s_z;
    t_side                     r_s_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_sx   <= r_m_sx;
            r_s_sy   <= r_m_sy;
            r_s_x    <= RW'(r_m_xhi) + RW'(r_m_xlo[63:32]);
            r_s_y    <= RW'(r_m_yhi) + RW'(r_m_ylo[63:32]);
            r_s_z    <= r_m_z;
            r_s_side <= r_m_side;
        end
    end

    // ------------------------------------------------------------------
    // round stage: sign back on and round half up in one add, ~r + 1 folded in
    // ------------------------------------------------------------------
    logic [RW1-1:0]            w_tx;
    logic [RW1-1:0]            w_ty;
    logic [RW1-1:0]            w_rx;
    logic [RW1-1:0]            w_ry;
    logic signed [Z_WIDTH-1:0] w_zr;

    always_comb begin
        w_tx = r_s_sx ? ~{1'b0, r_s_x} : {1'b0, r_s_x};
        w_ty = r_s_sy ? ~{1'b0, r_s_y} : {1'b0, r_s_y};
        w_rx = w_tx + (r_s_sx ? RND_NEG : RND_POS);
        w_ry = w_ty + (r_s_sy ? RND_NEG : RND_POS);
        w_zr = r_s_z + Z_HALF_LSB;
    end

    logic                     r_r_valid;
    logic signed [QW-1:0]     r_r_x;
    logic signed [QW-1:0]     r_r_y;
    logic signed [WP1-1:0]    r_r_ang;
    t_side                    r_r_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_x    <= w_rx[RW1-1:GUARD_BITS];
            r_r_y    <= w_ry[RW1-1:GUARD_BITS];
            r_r_ang  <= w_zr[Z_WIDTH-1:SHIFT];
            r_r_side <= r_s_side;
        end
    end

    // ------------------------------------------------------------------
    // output stage: pick the echoes or the cordic results, then saturate
    // ------------------------------------------------------------------
    logic signed [QW-1:0]  w_x_hi;
    logic signed [QW-1:0]  w_cx;
    logic signed [QW-1:0]  w_cy;
    logic signed [WP1-1:0] w_ang_sel;
    logic signed [WP1-1:0] w_ang_sat;
    logic signed [WP1-1:0] w_abs_a;
    logic signed [WP1-1:0] w_ext_a;
    logic signed [DATA_WIDTH-1:0] w_ox;
    logic signed [DATA_WIDTH-1:0] w_oy;
    logic signed [WP1-1:0]        w_om;
    logic signed [DATA_WIDTH-1:0] w_oa;

    always_comb begin
        // the x lane is a magnitude in vectoring mode, a coordinate otherwise
        w_x_hi  = (r_r_side.mode == REQ_POLAR) ? COORD_HI : MAG_HI_Q;
        w_cx    = (r_r_x > w_x_hi) ? w_x_hi : ((r_r_x < COORD_LO) ? COORD_LO : r_r_x);
        w_cy    = (r_r_y > COORD_HI) ? COORD_HI : ((r_r_y < COORD_LO) ? COORD_LO : r_r_y);

        w_ext_a   = WP1'(r_r_side.a);
        w_abs_a   = r_r_side.a[DATA_WIDTH-1] ? -w_ext_a : w_ext_a;
        w_ang_sel = (r_r_side.mode == REQ_POLAR) ? w_ext_a : r_r_ang;
        w_ang_sat = (w_ang_sel > PI_OUT) ? PI_OUT
                  : ((w_ang_sel < -PI_OUT) ? -PI_OUT : w_ang_sel);

        unique case (r_r_side.mode)
            REQ_POLAR: begin
                w_ox = w_cx[DATA_WIDTH-1:0];
                w_oy = w_cy[DATA_WIDTH-1:0];
                w_om = WP1'(r_r_side.b);
                w_oa = w_ang_sat[DATA_WIDTH-1:0];
            end
            REQ_RECT: begin
                w_ox = r_r_side.a;
                w_oy = r_r_side.b;
                if (r_r_side.axis) begin
                    // on the x axis, zero vector included
                    w_om = w_abs_a;
                    w_oa = r_r_side.a[DATA_WIDTH-1] ? PI_OUT[DATA_WIDTH-1:0] : '0;
                end else begin
                    w_om = w_cx[WP1-1:0];
                    w_oa = w_ang_sat[DATA_WIDTH-1:0];
                end
            end
            default: begin
                w_ox = r_r_side.a;
                w_oy = r_r_side.b;
                w_om = w_abs_a;
                w_oa = '0;
            end
        endcase
    end

    logic signed [DATA_WIDTH-1:0] r_out_x;
    logic signed [DATA_WIDTH-1:0] r_out_y;
    logic signed [WP1-1:0]        r_out_magnitude;
    logic signed [DATA_WIDTH-1:0] r_out_angle;
    t_req_mode                    r_out_mode;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x         <= w_ox;
            r_out_y         <= w_oy;
            r_out_magnitude <= w_om;
            r_out_angle     <= w_oa;
            r_out_mode      <= r_r_side.mode;
        end
    end

    // ------------------------------------------------------------------
    // valid bits, cleared by reset, moved with the common enable
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_a_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_r_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid     <= {r_valid[ITERATIONS-1:0], i_in_valid};
            r_a_valid   <= r_valid[ITERATIONS];
            r_m_valid   <= r_a_valid;
            r_s_valid   <= r_m_valid;
            r_r_valid   <= r_s_valid;
            r_out_valid <= r_r_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_magnitude = r_out_magnitude;
    assign o_out_angle     = r_out_angle;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the input side only stalls behind a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output word");

    // angle never leaves [-pi, pi]
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_angle <= PI_OUT) && (o_out_angle >= -PI_OUT)))
        else $error("angle out of range");

    // vectoring never yields a negative length
    a_rect_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_mode == REQ_RECT)) |-> !o_out_magnitude[DATA_WIDTH])
        else $error("negative magnitude from rectangular input");

    // rectangular word on the x axis gives angle zero or pi
    a_rect_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_mode == REQ_RECT) && (o_out_y == '0))
        |-> ((o_out_angle == '0) || (o_out_angle == PI_OUT[DATA_WIDTH-1:0])))
        else $error("axis vector with off-axis angle");

    // zero length in polar form gives the origin
    a_polar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_mode == REQ_POLAR) && (o_out_magnitude == '0))
        |-> ((o_out_x == '0) && (o_out_y == '0)))
        else $error("zero polar magnitude gave nonzero coordinates");

endmodule
